>>> sv/atapio_pkg.sv
package atapio_pkg;

  localparam int WordsPerSectorDef = 256;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam logic [1:0] OUT_REG    = 2'd0;
  localparam logic [1:0] OUT_DATA   = 2'd1;
  localparam logic [1:0] OUT_FINISH = 2'd2;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_ZERO  = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;

  localparam logic [7:0] DEV_LBA_MODE     = 8'hE0;
  localparam logic [7:0] CMD_READ_SECTORS = 8'h20;
  localparam logic [7:0] STATUS_POLL_MASK = 8'h89;
  localparam logic [7:0] STAT_DATA_REQ    = 8'h08;
  localparam logic [7:0] STATUS_FAIL_MASK = 8'h21;

  localparam logic [2:0] OFF_FEATURES = 3'd1;
  localparam logic [2:0] OFF_COUNT    = 3'd2;
  localparam logic [2:0] OFF_LBA_LO   = 3'd3;
  localparam logic [2:0] OFF_LBA_MID  = 3'd4;
  localparam logic [2:0] OFF_LBA_HI   = 3'd5;
  localparam logic [2:0] OFF_DEVICE   = 3'd6;
  localparam logic [2:0] OFF_COMMAND  = 3'd7;

  localparam logic [2:0] LAST_REG_STEP = 3'd6;

  typedef enum logic [1:0] {
    DESC_START  = 2'd0,
    DESC_FINISH = 2'd1,
    DESC_DATA   = 2'd2
  } desc_kind_t;

  typedef struct packed {
    desc_kind_t  kind;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [15:0] word;
    logic [15:0] index;
    logic [1:0]  code;
    logic        done;
  } desc_t;

  function automatic logic [2:0] reg_offset(input logic [2:0] step);
    logic [2:0] off;
    unique case (step)
      3'd0:    off = OFF_DEVICE;
      3'd1:    off = OFF_FEATURES;
      3'd2:    off = OFF_COUNT;
      3'd3:    off = OFF_LBA_LO;
      3'd4:    off = OFF_LBA_MID;
      3'd5:    off = OFF_LBA_HI;
      default: off = OFF_COMMAND;
    endcase
    return off;
  endfunction

  function automatic logic [7:0] reg_value(input logic [2:0] step, input logic [27:0] lba,
                                           input logic [7:0] count);
    logic [7:0] val;
    unique case (step)
      3'd0:    val = DEV_LBA_MODE | {4'd0, lba[27:24]};
      3'd1:    val = 8'd0;
      3'd2:    val = count;
      3'd3:    val = lba[7:0];
      3'd4:    val = lba[15:8];
      3'd5:    val = lba[23:16];
      default: val = CMD_READ_SECTORS;
    endcase
    return val;
  endfunction

endpackage

>>> sv/atapio_emit.sv
module atapio_emit
  import atapio_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  desc_t       load_desc,
  output logic        drain,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  port_offset,
  output logic [7:0]  write_value,
  output logic [15:0] word_value,
  output logic [15:0] word_index,
  output logic [1:0]  result_code,
  output logic        last
);

  logic       slot_valid;
  logic [2:0] step;
  desc_t      desc;
  logic       at_end;

  always_comb begin
    unique case (desc.kind)
      DESC_START: at_end = (step == LAST_REG_STEP);
      DESC_DATA:  at_end = desc.done ? (step == 3'd1) : 1'b1;
      default:    at_end = 1'b1;
    endcase
  end

  assign result_valid = slot_valid;
  assign drain        = slot_valid && result_ready && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      step       <= 3'd0;
    end else if (load) begin
      slot_valid <= 1'b1;
      step       <= 3'd0;
    end else if (slot_valid && result_ready) begin
      if (at_end) begin
        slot_valid <= 1'b0;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= load_desc;
    end
  end

  always_comb begin
    out_kind    = OUT_FINISH;
    port_offset = 3'd0;
    write_value = 8'd0;
    word_value  = 16'd0;
    word_index  = 16'd0;
    result_code = 2'd0;
    last        = at_end;
    unique case (desc.kind)
      DESC_START: begin
        out_kind    = OUT_REG;
        port_offset = reg_offset(step);
        write_value = reg_value(step, desc.lba, desc.count);
      end
      DESC_DATA: begin
        if (step == 3'd0) begin
          out_kind   = OUT_DATA;
          word_value = desc.word;
          word_index = desc.index;
        end else begin
          result_code = RES_OK;
        end
      end
      default: begin
        result_code = desc.code;
      end
    endcase
  end

endmodule

>>> sv/ata_pio_read_sequencer.sv
// Channel   Handshake                  Word carried
// item      item_valid / item_ready    kind, lba, num_sectors, status_byte, data_word
// result    result_valid / result_ready out_kind, port_offset, write_value, word_value,
//                                       word_index, result_code, last
//
// Status and data words are taken one per cycle while results drain; a data word's result
// appears the next cycle. A start request gives seven results from the result register, and
// the final data word of a transfer gives two; the next word is taken as the last one is taken.
// Reset is synchronous and returns the sequencer to idle with the result register empty.
// A stalled result side holds the item side once the result register is full.
module ata_pio_read_sequencer
  import atapio_pkg::*;
#(
  parameter int WORDS_PER_SECTOR = WordsPerSectorDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [27:0] lba,
  input  logic [7:0]  num_sectors,
  input  logic [7:0]  status_byte,
  input  logic [15:0] data_word,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  port_offset,
  output logic [7:0]  write_value,
  output logic [15:0] word_value,
  output logic [15:0] word_index,
  output logic [1:0]  result_code,
  output logic        last
);

  localparam int WisW = $clog2(WORDS_PER_SECTOR) + 1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        sectors_left, sectors_left_next;
  logic [WisW-1:0]   word_in_sector, word_in_sector_next;
  logic [15:0]       transfer_index, transfer_index_next;
  logic              accept;
  logic              push;
  desc_t             push_desc;
  logic              drain;
  logic [WisW-1:0]   wis_inc;
  logic [7:0]        sl_dec;

  assign accept = item_valid && item_ready;
  assign wis_inc = word_in_sector + WisW'(1);
  assign sl_dec  = sectors_left - 8'd1;

  always_comb begin
    phase_next          = phase;
    sectors_left_next   = sectors_left;
    word_in_sector_next = word_in_sector;
    transfer_index_next = transfer_index;
    push                = 1'b0;
    push_desc.kind      = DESC_FINISH;
    push_desc.lba       = lba;
    push_desc.count     = num_sectors;
    push_desc.word      = data_word;
    push_desc.index     = transfer_index;
    push_desc.code      = RES_OK;
    push_desc.done      = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (kind == KIND_START) begin
          push = 1'b1;
          if (num_sectors == 8'd0) begin
            push_desc.code = RES_ZERO;
          end else begin
            push_desc.kind      = DESC_START;
            phase_next          = PH_WAIT;
            sectors_left_next   = num_sectors;
            word_in_sector_next = '0;
            transfer_index_next = 16'd0;
          end
        end
      end
      PH_WAIT: begin
        if (kind == KIND_STATUS) begin
          if ((status_byte & STATUS_POLL_MASK) == STAT_DATA_REQ) begin
            phase_next = PH_DATA;
          end else if ((status_byte & STATUS_FAIL_MASK) != 8'd0) begin
            push           = 1'b1;
            push_desc.code = RES_ERROR;
            phase_next     = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        if (kind == KIND_DATA) begin
          push                = 1'b1;
          push_desc.kind      = DESC_DATA;
          transfer_index_next = transfer_index + 16'd1;
          word_in_sector_next = wis_inc;
          if (wis_inc >= WisW'(WORDS_PER_SECTOR)) begin
            word_in_sector_next = '0;
            sectors_left_next   = sl_dec;
            if (sl_dec == 8'd0) begin
              push_desc.done = 1'b1;
              phase_next     = PH_IDLE;
            end else begin
              phase_next = PH_WAIT;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      sectors_left   <= 8'd0;
      word_in_sector <= '0;
      transfer_index <= 16'd0;
    end else if (accept) begin
      phase          <= phase_next;
      sectors_left   <= sectors_left_next;
      word_in_sector <= word_in_sector_next;
      transfer_index <= transfer_index_next;
    end
  end

  assign item_ready = !result_valid || drain;

  atapio_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && push),
    .load_desc    (push_desc),
    .drain        (drain),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .port_offset  (port_offset),
    .write_value  (write_value),
    .word_value   (word_value),
    .word_index   (word_index),
    .result_code  (result_code),
    .last         (last)
  );

  a_data_has_sectors: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (sectors_left != 8'd0))
    else $error("data phase entered with no sectors left");

  a_index_in_step: assert property (@(posedge clk) disable iff (rst)
    transfer_index[WisW-2:0] == word_in_sector[WisW-2:0])
    else $error("transfer index and word count disagree");

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_kind == OUT_FINISH) |-> last)
    else $error("finish result not marked last");

  a_command_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_kind == OUT_REG && last) |->
      (port_offset == OFF_COMMAND && write_value == CMD_READ_SECTORS))
    else $error("register burst did not close with the command write");

endmodule

>>> tb/sv/tb_ata_pio_read_sequencer.sv
`timescale 1ns / 100ps

module tb_ata_pio_read_sequencer;
  import atapio_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SECTOR_WORDS = 256;
  localparam logic [7:0] STAT_BUSY = 8'h80;
  localparam logic [7:0] STAT_ERROR = 8'h01;
  localparam logic [7:0] STAT_FAULT = 8'h20;

  typedef enum logic [1:0] {
    XFER_IDLE,
    XFER_WAIT,
    XFER_DATA
  } xfer_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [7:0]  status;
    logic [15:0] data;
  } host_item_t;

  typedef struct packed {
    logic [1:0]  okind;
    logic [2:0]  offset;
    logic [7:0]  wvalue;
    logic [15:0] word;
    logic [15:0] index;
    logic [1:0]  code;
    logic        last;
  } host_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  kind = '0;
  logic [27:0] lba = '0;
  logic [7:0]  num_sectors = '0;
  logic [7:0]  status_byte = '0;
  logic [15:0] data_word = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [2:0]  port_offset;
  logic [7:0]  write_value;
  logic [15:0] word_value;
  logic [15:0] word_index;
  logic [1:0]  result_code;
  logic        last;

  host_item_t   pending_items[$];
  host_result_t expected_results[$];
  host_item_t   cur_item;
  host_result_t want_result;
  bit           item_taken = 1'b0;
  bit           calm_mode = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  int unsigned  error_count = 0;

  xfer_phase_t  xfer_phase = XFER_IDLE;
  logic [7:0]   sectors_to_go = '0;
  logic [8:0]   words_done = '0;
  logic [15:0]  xfer_index = '0;

  ata_pio_read_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .lba          (lba),
    .num_sectors  (num_sectors),
    .status_byte  (status_byte),
    .data_word    (data_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .port_offset  (port_offset),
    .write_value  (write_value),
    .word_value   (word_value),
    .word_index   (word_index),
    .result_code  (result_code),
    .last         (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5000000;
    $display("[ata_pio_read_sequencer] ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic host_result_t make_result(logic [1:0] okind, logic [2:0] offset,
                                               logic [7:0] wvalue, logic [15:0] word,
                                               logic [15:0] index, logic [1:0] code,
                                               logic is_last);
    host_result_t r;
    r.okind = okind;
    r.offset = offset;
    r.wvalue = wvalue;
    r.word = word;
    r.index = index;
    r.code = code;
    r.last = is_last;
    return r;
  endfunction

  task automatic predict_sequencer(input host_item_t it);
    logic [15:0] this_index;
    logic        finished;
    if (it.kind == KIND_START && xfer_phase == XFER_IDLE) begin
      if (it.count == 8'd0) begin
        expected_results.push_back(make_result(OUT_FINISH, '0, '0, '0, '0, RES_ZERO, 1'b1));
      end else begin
        expected_results.push_back(make_result(OUT_REG, OFF_DEVICE,
                                               DEV_LBA_MODE | {4'd0, it.lba[27:24]},
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_FEATURES, 8'd0,
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_COUNT, it.count,
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_LBA_LO, it.lba[7:0],
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_LBA_MID, it.lba[15:8],
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_LBA_HI, it.lba[23:16],
                                               '0, '0, RES_OK, 1'b0));
        expected_results.push_back(make_result(OUT_REG, OFF_COMMAND, CMD_READ_SECTORS,
                                               '0, '0, RES_OK, 1'b1));
        xfer_phase = XFER_WAIT;
        sectors_to_go = it.count;
        words_done = '0;
        xfer_index = '0;
      end
    end else if (it.kind == KIND_STATUS && xfer_phase == XFER_WAIT) begin
      if ((it.status & STATUS_POLL_MASK) == STAT_DATA_REQ) begin
        xfer_phase = XFER_DATA;
      end else if ((it.status & STATUS_FAIL_MASK) != 8'd0) begin
        expected_results.push_back(make_result(OUT_FINISH, '0, '0, '0, '0, RES_ERROR, 1'b1));
        xfer_phase = XFER_IDLE;
      end
    end else if (it.kind == KIND_DATA && xfer_phase == XFER_DATA) begin
      finished = 1'b0;
      this_index = xfer_index;
      xfer_index = xfer_index + 16'd1;
      words_done = words_done + 9'd1;
      if (words_done >= SECTOR_WORDS) begin
        words_done = '0;
        sectors_to_go = sectors_to_go - 8'd1;
        if (sectors_to_go == 8'd0) begin
          finished = 1'b1;
          xfer_phase = XFER_IDLE;
        end else begin
          xfer_phase = XFER_WAIT;
        end
      end
      expected_results.push_back(make_result(OUT_DATA, '0, '0, it.data, this_index,
                                             RES_OK, !finished));
      if (finished) begin
        expected_results.push_back(make_result(OUT_FINISH, '0, '0, '0, '0, RES_OK, 1'b1));
      end
    end
  endtask

  task automatic report_error(input string msg);
    error_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      predict_sequencer(cur_item);
      item_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      item_taken = 1'b0;
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        kind <= cur_item.kind;
        lba <= cur_item.lba;
        num_sectors <= cur_item.count;
        status_byte <= cur_item.status;
        data_word <= cur_item.data;
        item_valid <= 1'b1;
        send_gap = pick_gap();
        if ($urandom_range(0, 199) == 0) begin
          calm_mode = !calm_mode;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (recv_stall != 0) begin
        result_ready <= 1'b0;
        recv_stall--;
      end else begin
        result_ready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected word, kind %0d", out_kind));
      end else begin
        want_result = expected_results.pop_front();
        check_field("out_kind", 16'(out_kind), 16'(want_result.okind));
        check_field("port_offset", 16'(port_offset), 16'(want_result.offset));
        check_field("write_value", 16'(write_value), 16'(want_result.wvalue));
        check_field("word_value", word_value, want_result.word);
        check_field("word_index", word_index, want_result.index);
        check_field("result_code", 16'(result_code), 16'(want_result.code));
        check_field("last", 16'(last), 16'(want_result.last));
      end
    end
  end

  task automatic push_item(input logic [1:0] k, input logic [27:0] a, input logic [7:0] n,
                           input logic [7:0] s, input logic [15:0] d);
    host_item_t it;
    it.kind = k;
    it.lba = a;
    it.count = n;
    it.status = s;
    it.data = d;
    pending_items.push_back(it);
  endtask

  task automatic push_stray(input logic [1:0] k);
    push_item(k, 28'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic push_words(input int n);
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 2))
          0: push_stray(KIND_START);
          1: push_stray(KIND_STATUS);
          default: push_stray(KIND_UNUSED);
        endcase
      end
      d = 16'($urandom);
      if ($urandom_range(0, 15) == 0) begin
        d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      push_item(KIND_DATA, '0, '0, '0, d);
    end
  endtask

  task automatic push_not_ready();
    logic [7:0] s;
    s = 8'($urandom);
    if ($urandom_range(0, 1)) begin
      s = (s | STAT_BUSY) & ~STATUS_FAIL_MASK;
    end else begin
      s = s & ~(STAT_DATA_REQ | STATUS_FAIL_MASK);
    end
    push_item(KIND_STATUS, 28'($urandom), 8'($urandom), s, 16'($urandom));
  endtask

  task automatic push_failure();
    logic [7:0] s;
    s = 8'($urandom);
    if ($urandom_range(0, 1)) begin
      s = s | STAT_ERROR;
    end else begin
      s = (s | STAT_FAULT) & ~STAT_DATA_REQ;
    end
    push_item(KIND_STATUS, 28'($urandom), 8'($urandom), s, 16'($urandom));
  endtask

  task automatic push_transfer();
    int unsigned r;
    int          n;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = 0;
    end else if (r < 60) begin
      n = 1;
    end else begin
      n = $urandom_range(2, 255);
    end
    push_item(KIND_START, 28'($urandom), n[7:0], 8'($urandom), 16'($urandom));
    if (n == 0) begin
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: push_stray(KIND_START);
          1: push_stray(KIND_DATA);
          default: push_stray(KIND_UNUSED);
        endcase
      end else begin
        push_not_ready();
      end
    end
    push_failure();
  endtask

  initial begin
    push_item(KIND_START, 28'h0ABCDEF, 8'd0, 8'h00, 16'h0000);
    push_item(KIND_DATA, 28'h0000000, 8'd0, 8'h00, 16'hFFFF);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, STAT_DATA_REQ, 16'h0000);
    push_item(KIND_UNUSED, 28'hFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    push_item(KIND_START, 28'hFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    push_item(KIND_START, 28'h0000000, 8'd1, 8'h00, 16'h0000);
    push_item(KIND_DATA, 28'h0000000, 8'd0, 8'h00, 16'h1234);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h00, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h80, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h88, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h51, 16'h0000);
    push_item(KIND_START, 28'h0000000, 8'd1, 8'h00, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h20, 16'h0000);
    push_item(KIND_START, 28'h5A5A5A5, 8'd1, 8'h00, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, 8'h68, 16'h0000);
    push_item(KIND_DATA, 28'h0000000, 8'd0, 8'h00, 16'h0000);
    push_item(KIND_DATA, 28'h0000000, 8'd0, 8'h00, 16'hFFFF);
    push_item(KIND_START, 28'h1234567, 8'd3, 8'h00, 16'h0000);
    push_item(KIND_STATUS, 28'h0000000, 8'd0, STAT_ERROR, 16'h0000);
    push_item(KIND_UNUSED, 28'h0000000, 8'd0, 8'h00, 16'h0000);
    push_words(SECTOR_WORDS - 2);
    repeat (8) push_transfer();

    while (pending_items.size() != 0 || item_valid) begin
      @(posedge clk);
    end
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[ata_pio_read_sequencer] OK");
    end else begin
      $display("[ata_pio_read_sequencer] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/atapio_pkg.sv
sv/atapio_emit.sv
sv/ata_pio_read_sequencer.sv
tb/sv/tb_ata_pio_read_sequencer.sv
